// File: rtl/gf2ieb_pkg.sv
// ---------------------------------------------------------------------------
// GF(2) echelon basis package
// Shared sizes, input codes and the control and status bundles that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package gf2ieb_pkg;

  // Number of bit positions in one vector and the basis capacity in rows.
  localparam int unsigned VEC_BITS = 64;
  // Width of the vector field on the port.
  localparam int unsigned VEC_W    = 64;
  // Width of a pivot index.
  localparam int unsigned PIV_W    = (VEC_BITS > 1) ? $clog2(VEC_BITS) : 1;
  // Width of the row counter, which must hold VEC_BITS itself.
  localparam int unsigned CNT_W    = $clog2(VEC_BITS + 1);
  // Width of one stored entry: pivot index above the row bits.
  localparam int unsigned ROW_W    = VEC_BITS + PIV_W;
  // Widths of the kind field, the active bit count and the rank.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ACT_W    = 7;
  localparam int unsigned RANK_W   = 7;

  // Reset value of the active bit count.
  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(64);

  // Input item codes.
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // an input transfer happens this cycle
    logic walk;      // reduce against the stored rows
    logic finish;    // check the residual and store it if it qualifies
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done; // every stored row has been applied
  } status_t;

endpackage

// File: rtl/gf2ieb_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module gf2ieb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gf2ieb_ctrl.sv
// ---------------------------------------------------------------------------
// GF(2) echelon basis controller
// Sequences one item at a time: accept, walk the stored rows and finish for
// an insert or query, and hand the result to the output register.
// ---------------------------------------------------------------------------
module gf2ieb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [gf2ieb_pkg::KIND_W-1:0] in_kind_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gf2ieb_pkg::cmd_t              cmd_o,
  input  gf2ieb_pkg::status_t           status_i
);
  import gf2ieb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;
  logic   out_xfer;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Commands decoded from the state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = in_xfer;
    cmd_o.walk     = (state_q == ST_WALK);
    cmd_o.finish   = (state_q == ST_FINISH);
    cmd_o.load_out = (state_q == ST_EMIT) && out_free;
  end

  // Next state and output valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_INSERT || in_kind_i == KIND_QUERY) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result loaded into the output register shows as valid next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  // A finished item always goes to the emit step next.
  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> (state_q == ST_EMIT))
    else $error("finish not followed by emit");

endmodule

// File: rtl/gf2ieb_dp.sv
// ---------------------------------------------------------------------------
// GF(2) echelon basis datapath
// Working vector, row store, row counter, pivot search and result register.
// ---------------------------------------------------------------------------
module gf2ieb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gf2ieb_pkg::KIND_W-1:0] in_kind_i,
  input  logic [gf2ieb_pkg::VEC_W-1:0]  in_vector_i,
  input  logic                          cfg_we_i,
  input  logic [gf2ieb_pkg::ACT_W-1:0]  cfg_wdata_i,
  output logic                          out_in_span_o,
  output logic                          out_added_o,
  output logic [gf2ieb_pkg::RANK_W-1:0] out_rank_o,
  input  gf2ieb_pkg::cmd_t              cmd_i,
  output gf2ieb_pkg::status_t           status_o
);
  import gf2ieb_pkg::*;

  logic [ACT_W-1:0]    active_q;
  logic [CNT_W-1:0]    rows_q;
  logic [KIND_W-1:0]   kind_q;
  logic [VEC_BITS-1:0] vec_q, vec_d;
  logic [CNT_W-1:0]    issue_q;
  logic                rd_vld_q;
  logic                span_q, added_q;
  logic                out_span_q, out_added_q;
  logic [RANK_W-1:0]   out_rank_q;

  logic                rd_en;
  logic [ROW_W-1:0]    rd_data;
  logic [VEC_BITS-1:0] rd_row;
  logic [PIV_W-1:0]    rd_piv;
  logic [VEC_BITS-1:0] low_iso;
  logic [PIV_W-1:0]    low_pos;
  logic                res_zero;
  logic                store;

  // Row store: pivot index above the row bits.
  gf2ieb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(VEC_BITS)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(rows_q[PIV_W-1:0]),
    .wdata_i({low_pos, vec_q}),
    .re_i   (rd_en),
    .raddr_i(issue_q[PIV_W-1:0]),
    .rdata_o(rd_data)
  );

  assign rd_row = rd_data[VEC_BITS-1:0];
  assign rd_piv = rd_data[ROW_W-1:VEC_BITS];

  // Reads are issued back to back; each returned row is applied in the cycle after its read.
  assign rd_en              = cmd_i.walk && (issue_q < rows_q);
  assign status_o.walk_done = (issue_q == rows_q) && !rd_vld_q;

  // Lowest set bit of the residual: isolate it, then encode its position.
  assign low_iso = vec_q & (~vec_q + VEC_BITS'(1));
  always_comb begin
    low_pos = '0;
    for (int b = 0; b < VEC_BITS; b++) begin
      if (low_iso[b]) begin
        low_pos = low_pos | PIV_W'(b);
      end
    end
  end

  assign res_zero = (vec_q == '0);
  assign store    = cmd_i.finish && (kind_q == KIND_INSERT) && !res_zero
                    && (ACT_W'(low_pos) < active_q) && (rows_q < CNT_W'(VEC_BITS));

  // Working vector: load on transfer, XOR a row in where its pivot bit is set.
  always_comb begin
    vec_d = vec_q;
    if (cmd_i.start) begin
      vec_d = in_vector_i[VEC_BITS-1:0];
    end else if (rd_vld_q && vec_q[rd_piv]) begin
      vec_d = vec_q ^ rd_row;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
    if (cmd_i.start) begin
      kind_q <= in_kind_i;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Row count, read sequencing and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      span_q   <= 1'b0;
      added_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.start) begin
        issue_q <= '0;
        span_q  <= 1'b0;
        added_q <= 1'b0;
        if (in_kind_i == KIND_CLEAR) begin
          rows_q <= '0;
        end
      end else if (rd_en) begin
        issue_q <= issue_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        span_q  <= res_zero;
        added_q <= store;
      end
      if (store) begin
        rows_q <= rows_q + CNT_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_span_q  <= span_q;
      out_added_q <= added_q;
      out_rank_q  <= RANK_W'(rows_q);
    end
  end

  assign out_in_span_o = out_span_q;
  assign out_added_o   = out_added_q;
  assign out_rank_o    = out_rank_q;

  // The basis never holds more rows than there are bit positions.
  a_rows_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= CNT_W'(VEC_BITS))
    else $error("row count above capacity");

  // Reads never run past the stored rows.
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= rows_q)
    else $error("row read beyond the basis");

  // A vector in the span is never stored.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(span_q && added_q))
    else $error("in-span vector stored");

  // A stored row bumps the count by one.
  a_store_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store |=> (rows_q == $past(rows_q) + CNT_W'(1)))
    else $error("row count not advanced on store");

endmodule

// File: rtl/gf2_incremental_echelon_basis.sv
// ---------------------------------------------------------------------------
// GF(2) incremental echelon basis
// Keeps a row-echelon basis over GF(2) without back-reduction. Each item
// clears the basis, inserts a vector or asks whether a vector is in the span.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_kind_i, in_vector_i
//   out      output     out_valid_o / out_stall_i  out_in_span_o, out_added_o,
//                                                  out_rank_o
//   cfg      input      cfg_we_i                   cfg_wdata_i (active bits)
//
// An insert or query passes from its transfer through the walk, the finish
// step and the emit step into the result register. In the walk the row
// store is read one row per cycle through its single read port, and each
// row is applied in the cycle after its read; an empty basis needs no read.
// A clear or an unused code goes from its transfer straight to the emit
// step. One item is in work at a time; the next can be taken in the cycle
// after the result is loaded. Reset empties the basis and sets the active
// bit count to 64. A stalled result holds in the output register while the
// next item is taken, and that item waits to be loaded until the register
// is free.
// ---------------------------------------------------------------------------
module gf2_incremental_echelon_basis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gf2ieb_pkg::KIND_W-1:0] in_kind_i,
  input  logic [gf2ieb_pkg::VEC_W-1:0]  in_vector_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_in_span_o,
  output logic                          out_added_o,
  output logic [gf2ieb_pkg::RANK_W-1:0] out_rank_o,
  input  logic                          cfg_we_i,
  input  logic [gf2ieb_pkg::ACT_W-1:0]  cfg_wdata_i
);
  import gf2ieb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  gf2ieb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Row store and arithmetic.
  gf2ieb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_kind_i    (in_kind_i),
    .in_vector_i  (in_vector_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_in_span_o(out_in_span_o),
    .out_added_o  (out_added_o),
    .out_rank_o   (out_rank_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule
